[src/mtep_pkg.sv]
// Package for the track event parser: payload structs, phase codes, kinds.
// No dependencies.
package mtep_pkg;

    localparam int DEF_MAX_TRACK_ID = 1023;
    localparam int CHANNELS         = 16;
    localparam int TRK_W            = 10;
    localparam int DELTA_W          = 28;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       track_start;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  kind;
        logic [27:0] delta_time;
        logic [7:0]  status;
        logic [7:0]  data1;
        logic [7:0]  data2;
        logic [9:0]  dest_track;
        logic        last;
        logic        terminated;
    } t_out_item;

    typedef enum logic [2:0] {
        KIND_CHAN      = 3'd0,
        KIND_META      = 3'd1,
        KIND_META_NONE = 3'd2,
        KIND_SYSX      = 3'd3,
        KIND_SYSX_NONE = 3'd4,
        KIND_NO_STATUS = 3'd5,
        KIND_OVERLONG  = 3'd6
    } t_kind;

    typedef enum logic [2:0] {
        PH_DELTA, PH_STATUS, PH_DATA1, PH_DATA2,
        PH_META_LEN, PH_META_DATA, PH_SYS_LEN, PH_SYS_DATA
    } t_phase;

endpackage

[src/mtep_fifo.sv]
// Short result queue between the byte parser and the output port.
// Depends on mtep_pkg.
module mtep_fifo
    import mtep_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_out_item i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    t_out_item  r_mem [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_item  = r_mem[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    // store payload
    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
    end

    // advance pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end
endmodule

[src/mtep_parser.sv]
// Byte parser: decodes delta, status and data, keeps the channel map.
// Depends on mtep_pkg.
module mtep_parser
    import mtep_pkg::*;
#(
    parameter int MAX_TRACK_ID = DEF_MAX_TRACK_ID
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_step,
    input  t_in_item  i_item,
    output logic      o_res_valid,
    output t_out_item o_res
);
    localparam logic [TRK_W-1:0] TRACK_CAP =
        (MAX_TRACK_ID < 1023) ? TRK_W'(MAX_TRACK_ID) : TRK_W'(1023);

    t_phase            r_phase, n_phase;
    logic [27:0]       r_acc, n_acc;
    logic [2:0]        r_cnt, n_cnt;
    logic [27:0]       r_delta, n_delta;
    logic [7:0]        r_run, n_run;
    logic              r_run_v, n_run_v;
    logic [7:0]        r_first, n_first;
    logic [27:0]       r_rem, n_rem;
    logic [CHANNELS-1:0] r_map_v, n_map_v;
    logic [TRK_W-1:0]  r_map [CHANNELS];
    logic              r_pend, n_pend;
    logic [TRK_W-1:0]  r_tc, n_tc;
    logic [TRK_W-1:0]  r_mt, n_mt;
    logic              r_seen, n_seen;
    logic [7:0]        r_est, n_est;
    logic [TRK_W-1:0]  r_etrk, n_etrk;
    logic              map_wr;
    logic [3:0]        map_ch;

    // step the parser state for one byte
    always_comb begin
        logic [7:0]  b;
        logic [27:0] acc_nx;
        logic [2:0]  cnt_nx;
        logic        nd, no, lenstep, meta, lastb;
        logic [3:0]  hi;
        logic [7:0]  d1;
        b = i_item.data_byte;
        n_phase = r_phase; n_acc = r_acc; n_cnt = r_cnt; n_delta = r_delta;
        n_run = r_run; n_run_v = r_run_v; n_first = r_first; n_rem = r_rem;
        n_map_v = r_map_v; n_pend = r_pend; n_tc = r_tc; n_mt = r_mt;
        n_seen = r_seen; n_est = r_est; n_etrk = r_etrk;
        map_wr = 1'b0; map_ch = 4'd0;
        o_res_valid = 1'b0;
        o_res = '0;
        o_res.last = 1'b1;
        lenstep = 1'b0; meta = 1'b0;
        hi = 4'd0; d1 = 8'd0; lastb = 1'b0;
        if (i_step && i_item.track_start) begin
            if (r_seen) n_tc = (r_tc < TRACK_CAP) ? r_tc + 1'b1 : TRACK_CAP;
            n_seen = 1'b1; n_mt = n_tc; n_map_v = '0; n_pend = 1'b1;
            n_run = 8'h80; n_run_v = 1'b0;
            n_phase = PH_DELTA; n_acc = '0; n_cnt = '0;
        end
        // number decode on the cleared or held accumulator
        acc_nx = {n_acc[20:0], b[6:0]};
        cnt_nx = n_cnt + 3'd1;
        nd = !b[7];
        no = b[7] && (cnt_nx >= 3'd4);
        if (i_step) begin
            case (n_phase)
                PH_DELTA: begin
                    n_acc = acc_nx; n_cnt = cnt_nx;
                    if (no) begin
                        o_res_valid = 1'b1; o_res.kind = KIND_OVERLONG;
                        n_acc = '0; n_cnt = '0;
                    end else if (nd) begin
                        n_delta = acc_nx; n_acc = '0; n_cnt = '0;
                        n_phase = PH_STATUS;
                    end
                end
                PH_STATUS, PH_DATA1: begin
                    if (n_phase == PH_STATUS && b[7]) begin
                        n_est = b; n_phase = PH_DATA1;
                    end else if (n_phase == PH_STATUS && !n_run_v) begin
                        o_res_valid = 1'b1; o_res.kind = KIND_NO_STATUS;
                        o_res.delta_time = r_delta; o_res.data1 = b;
                        n_phase = PH_DELTA; n_acc = '0; n_cnt = '0;
                    end else begin
                        if (n_phase == PH_STATUS) n_est = n_run;
                        if (n_est == 8'hFF) begin
                            n_first = b; n_etrk = n_mt; n_acc = '0; n_cnt = '0;
                            n_phase = PH_META_LEN;
                        end else begin
                            n_run = n_est; n_run_v = 1'b1;
                            map_ch = n_est[3:0];
                            if (n_map_v[map_ch]) begin
                                n_etrk = r_map[map_ch];
                            end else begin
                                if (n_pend) n_pend = 1'b0;
                                else n_tc = (n_tc < TRACK_CAP) ? n_tc + 1'b1 : TRACK_CAP;
                                map_wr = 1'b1; n_map_v[map_ch] = 1'b1; n_etrk = n_tc;
                            end
                            hi = n_est[7:4];
                            if (hi == 4'hC || hi == 4'hD) begin
                                o_res_valid = 1'b1; o_res.kind = KIND_CHAN;
                                o_res.delta_time = r_delta; o_res.status = n_est;
                                o_res.data1 = b; o_res.dest_track = n_etrk;
                                n_phase = PH_DELTA; n_acc = '0; n_cnt = '0;
                            end else if (hi == 4'hF) begin
                                acc_nx = {21'd0, b[6:0]}; cnt_nx = 3'd1;
                                no = 1'b0;
                                lenstep = 1'b1; meta = 1'b0;
                                n_phase = PH_SYS_LEN;
                            end else begin
                                n_first = b; n_phase = PH_DATA2;
                            end
                        end
                    end
                end
                PH_DATA2: begin
                    o_res_valid = 1'b1; o_res.kind = KIND_CHAN;
                    o_res.delta_time = r_delta; o_res.status = r_est;
                    o_res.data1 = r_first; o_res.data2 = b;
                    o_res.dest_track = r_etrk;
                    n_phase = PH_DELTA; n_acc = '0; n_cnt = '0;
                end
                PH_META_LEN: begin lenstep = 1'b1; meta = 1'b1; end
                PH_SYS_LEN:  begin lenstep = 1'b1; meta = 1'b0; end
                PH_META_DATA, PH_SYS_DATA: begin
                    meta = (n_phase == PH_META_DATA);
                    n_rem = r_rem - 28'd1;
                    lastb = (n_rem == 28'd0);
                    o_res_valid = 1'b1;
                    o_res.kind = meta ? KIND_META : KIND_SYSX;
                    o_res.delta_time = r_delta; o_res.status = r_est;
                    o_res.data1 = meta ? r_first : 8'd0; o_res.data2 = b;
                    o_res.dest_track = r_etrk; o_res.last = lastb;
                    o_res.terminated = !meta && lastb && (b == 8'hF7);
                    if (lastb) begin n_phase = PH_DELTA; n_acc = '0; n_cnt = '0; end
                end
                default: begin n_phase = PH_DELTA; n_acc = '0; n_cnt = '0; end
            endcase
            // finish a length byte
            if (lenstep) begin
                d1 = meta ? n_first : 8'd0;
                n_acc = acc_nx; n_cnt = cnt_nx;
                o_res.delta_time = r_delta; o_res.status = n_est;
                o_res.data1 = d1; o_res.dest_track = n_etrk;
                if (no) begin
                    o_res_valid = 1'b1; o_res.kind = KIND_OVERLONG;
                    n_phase = PH_DELTA; n_acc = '0; n_cnt = '0;
                end else if (nd) begin
                    n_rem = acc_nx; n_acc = '0; n_cnt = '0;
                    if (acc_nx == 28'd0) begin
                        o_res_valid = 1'b1;
                        o_res.kind = meta ? KIND_META_NONE : KIND_SYSX_NONE;
                        n_phase = PH_DELTA;
                    end else begin
                        n_phase = meta ? PH_META_DATA : PH_SYS_DATA;
                    end
                end
            end
        end
    end

    // hold channel map entries
    always_ff @(posedge i_clk) begin
        if (map_wr) r_map[map_ch] <= n_tc;
    end

    // advance state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_DELTA; r_acc <= '0; r_cnt <= '0; r_delta <= '0;
            r_run <= 8'h80; r_run_v <= 1'b0; r_first <= '0; r_rem <= '0;
            r_map_v <= '0; r_pend <= 1'b1; r_tc <= '0; r_mt <= '0;
            r_seen <= 1'b0; r_est <= '0; r_etrk <= '0;
        end else begin
            r_phase <= n_phase; r_acc <= n_acc; r_cnt <= n_cnt;
            r_delta <= n_delta; r_run <= n_run; r_run_v <= n_run_v;
            r_first <= n_first; r_rem <= n_rem; r_map_v <= n_map_v;
            r_pend <= n_pend; r_tc <= n_tc; r_mt <= n_mt; r_seen <= n_seen;
            r_est <= n_est; r_etrk <= n_etrk;
        end
    end
endmodule

[src/midi_track_event_parser_unit.sv]
// MIDI track event parser: one track byte in, at most one event result out,
// one byte per cycle. Depends on mtep_pkg, mtep_parser, mtep_fifo.
//
// Takes one track byte per cycle; the parser decodes each byte in the cycle
// it is accepted and writes any result into a two-entry queue that feeds
// the output port. Input is ready whenever the queue has room, so full rate
// holds while the output side keeps up; each result is registered in the
// queue before it reaches the output port.
module midi_track_event_parser_unit
    import mtep_pkg::*;
#(
    parameter int MAX_TRACK_ID = DEF_MAX_TRACK_ID
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_valid,
    output logic      o_ready,
    input  t_in_item  i_item,
    output logic      o_valid,
    input  logic      i_ready,
    output t_out_item o_item
);
    logic      step, res_v, q_ready;
    t_out_item res;

    // accept a byte only when a result can be stored
    assign o_ready = q_ready;
    assign step    = i_valid && q_ready;

    mtep_parser #(.MAX_TRACK_ID(MAX_TRACK_ID)) u_parser (
        .i_clk, .i_rst_n, .i_step(step), .i_item,
        .o_res_valid(res_v), .o_res(res)
    );

    mtep_fifo u_fifo (
        .i_clk, .i_rst_n, .i_valid(res_v), .o_ready(q_ready), .i_item(res),
        .o_valid, .i_ready, .o_item
    );
endmodule

[src/mtep_checker.sv]
// Port checker for the track event parser, bound to the top level.
// Depends on mtep_pkg.
module mtep_checker
    import mtep_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input t_out_item o_item,
    input logic      o_valid,
    input logic      i_ready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_item))
        else $error("output item changed while stalled");
    a_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_item.kind <= KIND_OVERLONG)
        else $error("bad kind");
    a_term: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.terminated |-> o_item.last && o_item.kind == KIND_SYSX)
        else $error("terminated off a final sysex byte");
    a_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_item.kind != KIND_META && o_item.kind != KIND_SYSX
        |-> o_item.last)
        else $error("single result event without last");
endmodule

bind midi_track_event_parser_unit mtep_checker u_chk (
    .i_clk, .i_rst_n, .o_item, .o_valid, .i_ready
);
